@@ rtl/psimd_pkg.sv @@
// Package with the operation codes and the request and lane result types of the packed SIMD unit.
package psimd_pkg;

  typedef enum logic [5:0] {
    OP_ADD       = 6'd0,
    OP_SUB       = 6'd1,
    OP_MUL       = 6'd2,
    OP_NEG       = 6'd3,
    OP_SHL       = 6'd4,
    OP_SRA       = 6'd5,
    OP_SRL       = 6'd6,
    OP_AND       = 6'd7,
    OP_OR        = 6'd8,
    OP_XOR       = 6'd9,
    OP_NOT       = 6'd10,
    OP_ANDNOT    = 6'd11,
    OP_CMPEQ     = 6'd12,
    OP_CMPLT_S   = 6'd13,
    OP_CMPLT_U   = 6'd14,
    OP_CMPGT_U   = 6'd15,
    OP_CMPLE_U   = 6'd16,
    OP_VEC_EQ    = 6'd17,
    OP_VEC_NE    = 6'd18,
    OP_EQ_ANY    = 6'd19,
    OP_MSB_MASK  = 6'd20,
    OP_SELECT    = 6'd21,
    OP_SPLAT     = 6'd22,
    OP_CREATE_SC = 6'd23,
    OP_NARROW    = 6'd24,
    OP_WIDEN_LO  = 6'd25,
    OP_WIDEN_HI  = 6'd26,
    OP_SHUFFLE1  = 6'd27,
    OP_SHUFFLE2  = 6'd28,
    OP_EXTRACT_S = 6'd29,
    OP_EXTRACT_U = 6'd30,
    OP_REPLACE   = 6'd31,
    OP_ALL_ONES  = 6'd32
  } op_t;

  typedef struct packed {
    op_t          op;
    logic [1:0]   lane_size;
    logic [127:0] a;
    logic [127:0] b;
    logic [127:0] c;
    logic [7:0]   shift_count;
    logic [7:0]   lane_index;
    logic [63:0]  scalar;
  } req_t;

  typedef struct packed {
    logic [127:0] vec;
    logic         eq_any;
    logic [15:0]  msb;
  } lane_res_t;

  typedef struct packed {
    logic [127:0] vec;
    logic [63:0]  scalar;
  } perm_res_t;

endpackage

@@ rtl/psimd_lane_alu.sv @@
// Per-lane arithmetic, shift, logic and compare operations for all four lane widths.
module psimd_lane_alu (
  input  psimd_pkg::req_t      req,
  output psimd_pkg::lane_res_t res
);

  logic [127:0] vec_sz [4];
  logic [3:0]   eqany_sz;
  logic [15:0]  msb_sz [4];

  for (genvar s = 0; s < 4; s++) begin : g_sz
    localparam int W  = 8 << s;
    localparam int N  = 128 / W;
    localparam int SB = 3 + s;
    logic [N-1:0] eq_l;
    logic [N-1:0] msb_l;
    logic [127:0] v;

    for (genvar i = 0; i < N; i++) begin : g_ln
      logic [W-1:0]  x;
      logic [W-1:0]  y;
      logic [W-1:0]  z;
      logic [W-1:0]  prod;
      logic [SB-1:0] sh;

      assign x  = req.a[i*W +: W];
      assign y  = req.b[i*W +: W];
      assign sh = req.shift_count[SB-1:0];

      if (W < 64) begin : g_mul
        assign prod = x * y;
      end else begin : g_mul
        logic [63:0] p0;
        logic [31:0] p1;
        logic [31:0] p2;
        assign p0   = x[31:0] * y[31:0];
        assign p1   = x[31:0] * y[63:32];
        assign p2   = x[63:32] * y[31:0];
        assign prod = p0 + {p1 + p2, 32'd0};
      end

      always_comb begin
        case (req.op)
          psimd_pkg::OP_ADD:     z = x + y;
          psimd_pkg::OP_SUB:     z = x - y;
          psimd_pkg::OP_MUL:     z = prod;
          psimd_pkg::OP_NEG:     z = '0 - x;
          psimd_pkg::OP_SHL:     z = x << sh;
          psimd_pkg::OP_SRA:     z = $unsigned($signed(x) >>> sh);
          psimd_pkg::OP_SRL:     z = x >> sh;
          psimd_pkg::OP_AND:     z = x & y;
          psimd_pkg::OP_OR:      z = x | y;
          psimd_pkg::OP_XOR:     z = x ^ y;
          psimd_pkg::OP_NOT:     z = ~x;
          psimd_pkg::OP_ANDNOT:  z = x & ~y;
          psimd_pkg::OP_CMPEQ:   z = {W{x == y}};
          psimd_pkg::OP_CMPLT_S: z = {W{$signed(x) < $signed(y)}};
          psimd_pkg::OP_CMPLT_U: z = {W{x < y}};
          psimd_pkg::OP_CMPGT_U: z = {W{x > y}};
          psimd_pkg::OP_CMPLE_U: z = {W{x <= y}};
          default:               z = '0;
        endcase
      end

      assign v[i*W +: W] = z;
      assign eq_l[i]     = (x == y);
      assign msb_l[i]    = x[W-1];
    end

    assign vec_sz[s]   = v;
    assign eqany_sz[s] = |eq_l;
    assign msb_sz[s]   = 16'(msb_l);
  end

  assign res.vec    = vec_sz[req.lane_size];
  assign res.eq_any = eqany_sz[req.lane_size];
  assign res.msb    = msb_sz[req.lane_size];

endmodule

@@ rtl/psimd_perm.sv @@
// Lane movement operations: select, splat, create scalar, narrow, widen, shuffles, extract, replace and all ones.
module psimd_perm (
  input  psimd_pkg::req_t      req,
  output psimd_pkg::perm_res_t res
);

  logic [127:0] vec_sz [4];
  logic [63:0]  sc_sz [4];
  logic [255:0] ab;
  logic [127:0] shuf2;

  assign ab = {req.b, req.a};

  for (genvar i = 0; i < 16; i++) begin : g_byte
    logic [4:0] k;
    assign k = req.c[i*8 +: 5];
    assign shuf2[i*8 +: 8] = ab[k*8 +: 8];
  end

  for (genvar s = 0; s < 4; s++) begin : g_sz
    localparam int W  = 8 << s;
    localparam int N  = 128 / W;
    localparam int LB = 4 - s;
    logic [W-1:0]  al [N];
    logic [LB-1:0] li;
    logic [W-1:0]  ext;
    logic [W-1:0]  sv;
    logic [127:0]  rep;
    logic [127:0]  shuf1;
    logic [127:0]  nar;
    logic [127:0]  wlo;
    logic [127:0]  whi;
    logic [127:0]  v;
    logic [63:0]   sc;

    assign li  = req.lane_index[LB-1:0];
    assign sv  = req.scalar[W-1:0];
    assign ext = al[li];

    for (genvar i = 0; i < N; i++) begin : g_ln
      logic [W-1:0] k;
      assign al[i]  = req.a[i*W +: W];
      assign k      = req.b[i*W +: W];
      assign rep[i*W +: W]   = (li == LB'(i)) ? sv : al[i];
      assign shuf1[i*W +: W] = (k < W'(N)) ? al[k[LB-1:0]] : '0;
    end

    if (W < 64) begin : g_nw
      for (genvar i = 0; i < N / 2; i++) begin : g_h
        assign nar[i*W +: W]         = req.a[i*2*W +: W];
        assign nar[(i+N/2)*W +: W]   = req.b[i*2*W +: W];
        assign wlo[i*2*W +: 2*W]     = (2*W)'(al[i]);
        assign whi[i*2*W +: 2*W]     = (2*W)'(al[i+N/2]);
      end
    end else begin : g_nw
      assign nar = {req.b[63:0], req.a[63:0]};
      assign wlo = {64'd0, req.a[63:0]};
      assign whi = {64'd0, req.a[127:64]};
    end

    always_comb begin
      v  = '0;
      sc = '0;
      case (req.op)
        psimd_pkg::OP_SPLAT:     v  = {N{sv}};
        psimd_pkg::OP_CREATE_SC: v  = 128'(sv);
        psimd_pkg::OP_NARROW:    v  = nar;
        psimd_pkg::OP_WIDEN_LO:  v  = wlo;
        psimd_pkg::OP_WIDEN_HI:  v  = whi;
        psimd_pkg::OP_SHUFFLE1:  v  = shuf1;
        psimd_pkg::OP_REPLACE:   v  = rep;
        psimd_pkg::OP_EXTRACT_S: sc = 64'($signed(ext));
        psimd_pkg::OP_EXTRACT_U: sc = 64'(ext);
        default:                 v  = '0;
      endcase
    end

    assign vec_sz[s] = v;
    assign sc_sz[s]  = sc;
  end

  always_comb begin
    res.scalar = sc_sz[req.lane_size];
    case (req.op)
      psimd_pkg::OP_SELECT:   res.vec = (req.b & req.a) | (req.c & ~req.a);
      psimd_pkg::OP_SHUFFLE2: res.vec = shuf2;
      psimd_pkg::OP_ALL_ONES: res.vec = '1;
      default:                res.vec = vec_sz[req.lane_size];
    endcase
  end

endmodule

@@ rtl/packed_simd_integer_alu_core.sv @@
// Top level of the packed SIMD integer unit: input register, operation units and result register.
//
//  channel  signals                                         direction
//  in       in_valid, in_stall, req_type .. scalar_in       item enters
//  out      out_valid, out_stall, res_lo, res_hi, scalar_out item leaves
//
// Every item passes from acceptance through the input register and then the result register;
// the unit takes one item per cycle while out_stall does not hold the output.
// Reset clears both valid flags; the payload registers are not reset.
// A stall on the output holds the result, and the input register fills behind it
// before in_stall rises.
module packed_simd_integer_alu_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [5:0]  req_type,
  input  logic [1:0]  lane_size,
  input  logic [63:0] a_lo,
  input  logic [63:0] a_hi,
  input  logic [63:0] b_lo,
  input  logic [63:0] b_hi,
  input  logic [63:0] c_lo,
  input  logic [63:0] c_hi,
  input  logic [7:0]  shift_count,
  input  logic [7:0]  lane_index,
  input  logic [63:0] scalar_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] res_lo,
  output logic [63:0] res_hi,
  output logic [63:0] scalar_out
);

  psimd_pkg::req_t        req;
  logic                   req_valid;
  logic                   advance;
  psimd_pkg::lane_res_t   lane_res;
  psimd_pkg::perm_res_t   perm_res;
  logic [127:0]           vec_next;
  logic [63:0]            scalar_next;

  assign advance  = !(out_valid && out_stall);
  assign in_stall = req_valid && !advance;

  psimd_lane_alu u_lane (.req(req), .res(lane_res));
  psimd_perm     u_perm (.req(req), .res(perm_res));

  always_comb begin
    vec_next    = '0;
    scalar_next = '0;
    case (req.op)
      psimd_pkg::OP_VEC_EQ:    scalar_next = 64'({req.a == req.b});
      psimd_pkg::OP_VEC_NE:    scalar_next = 64'({req.a != req.b});
      psimd_pkg::OP_EQ_ANY:    scalar_next = 64'(lane_res.eq_any);
      psimd_pkg::OP_MSB_MASK:  scalar_next = 64'(lane_res.msb);
      psimd_pkg::OP_EXTRACT_S,
      psimd_pkg::OP_EXTRACT_U: scalar_next = perm_res.scalar;
      psimd_pkg::OP_SELECT,
      psimd_pkg::OP_SPLAT,
      psimd_pkg::OP_CREATE_SC,
      psimd_pkg::OP_NARROW,
      psimd_pkg::OP_WIDEN_LO,
      psimd_pkg::OP_WIDEN_HI,
      psimd_pkg::OP_SHUFFLE1,
      psimd_pkg::OP_SHUFFLE2,
      psimd_pkg::OP_REPLACE,
      psimd_pkg::OP_ALL_ONES:  vec_next = perm_res.vec;
      default: begin
        if (req.op <= psimd_pkg::OP_CMPLE_U) begin
          vec_next = lane_res.vec;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= req_valid;
      end
      if (!in_stall) begin
        req_valid <= in_valid;
      end
    end
    if (in_valid && !in_stall) begin
      req.op          <= psimd_pkg::op_t'(req_type);
      req.lane_size   <= lane_size;
      req.a           <= {a_hi, a_lo};
      req.b           <= {b_hi, b_lo};
      req.c           <= {c_hi, c_lo};
      req.shift_count <= shift_count;
      req.lane_index  <= lane_index;
      req.scalar      <= scalar_in;
    end
    if (advance && req_valid) begin
      res_lo     <= vec_next[63:0];
      res_hi     <= vec_next[127:64];
      scalar_out <= scalar_next;
    end
  end

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !req_valid |-> !in_stall)
    else $error("input stalled with an empty input register");

  a_item_moves_on: assert property (@(posedge clk) disable iff (rst)
    (req_valid && advance) |=> out_valid)
    else $error("item lost between input and result registers");

  a_stall_keeps_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> req_valid)
    else $error("held item dropped from the input register");

  a_unknown_zero: assert property (@(posedge clk) disable iff (rst)
    (req_valid && advance && (req.op > psimd_pkg::OP_ALL_ONES)) |=>
      (res_lo == 64'd0 && res_hi == 64'd0 && scalar_out == 64'd0))
    else $error("unknown operation gave a nonzero result");

endmodule
